// ===== sv/pld_pkg.sv =====
package pld_pkg;

    // Field and register widths
    localparam int VALUE_W    = 32;
    localparam int COEFF_W    = 16;
    localparam int DIM_W      = 7;
    localparam int COORD_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Stream payload widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 32;

    // Default grid bounds
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    // Smallest grid edge in use
    localparam int MIN_DIM = 2;

    // Arithmetic widths: neighbor sum minus four times center, times k
    localparam int DIFF_W     = VALUE_W + 3;
    localparam int PROD_W     = DIFF_W + COEFF_W + 1;
    localparam int FRAC_SHIFT = 16;
    localparam int STEP_W     = PROD_W - FRAC_SHIFT;
    localparam int SUM_W      = STEP_W + 1;
    localparam int ROUND_HALF = 32768;

    // Reset values of the configuration registers
    localparam logic [COEFF_W-1:0] RATE_COEFF_RST = 16'd0;
    localparam logic [DIM_W-1:0]   ROWS_RST       = 7'd64;
    localparam logic [DIM_W-1:0]   COLS_RST       = 7'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE_COEFF  = 2'd0,
        CFG_ROWS_IN_USE = 2'd1,
        CFG_COLS_IN_USE = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_COMPUTE = 1'b1
    } opcode_t;

endpackage

// ===== sv/pld_grid_ram.sv =====
module pld_grid_ram
    import pld_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_ROWS * DEF_MAX_COLS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               aclk,
    input  logic               we,
    input  logic               re,
    input  logic [AW-1:0]      addr,
    input  logic [VALUE_W-1:0] wr_data,
    output logic [VALUE_W-1:0] rd_data
);

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    // Single port: one address per cycle for a write, a read or both
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wr_data;
        end
        if (re) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/periodic_laplacian_diffusion_step_top.sv =====
// Periodic five-point Laplacian diffusion step.
// Input channel s_*: one beat per item. s_tuser carries the opcode. A load
// beat writes cell_value into the grid at (row, col) and echoes it back. A
// compute beat reads the center cell and its four wrapped neighbors and
// returns old + k * (sum of neighbors - 4 * old), saturated to 32 bits, with
// m_tuser flagging the clipping.
// Output channel m_*: one beat per input beat, in order.
// Config channel cfg_*: always ready; write only while no item is in flight.
//
// Sequence: a load goes from accept straight to hand-off; a compute passes
// through accept, six slots of the single-port grid memory for five reads
// with a registered read port, multiply, round/saturate and hand-off. One
// item is in flight at a time, so a new item is taken only once the last
// one has left the hand-off state.
// The output register holds a finished result while the receiver stalls; the
// next item is accepted meanwhile and waits in the hand-off state only if its
// result is ready before the previous one is taken.
// Reset (aresetn low, synchronous) returns the sequencer to idle, drops any
// pending result and restores k = 0 and a 64 x 64 grid in use. The grid memory
// is not cleared; a cell must be loaded before a compute reads it.
module periodic_laplacian_diffusion_step_top
    import pld_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // row[5:0], col[11:6], cell_value[43:12]
    input  logic                  s_tuser,   // opcode[0]

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // new_value[31:0]
    output logic                  m_tuser,   // saturated[0]

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW_R  = $clog2(MAX_ROWS + 1);
    localparam int CW_C  = $clog2(MAX_COLS + 1);
    localparam int CW_RC = (CW_R > CW_C) ? CW_R : CW_C;
    localparam int CW    = (CW_RC > DIM_W) ? CW_RC : DIM_W;

    localparam logic [CW-1:0] ROWS_C = CW'(MAX_ROWS);
    localparam logic [CW-1:0] COLS_C = CW'(MAX_COLS);
    localparam logic [CW-1:0] MIN_C  = CW'(MIN_DIM);
    localparam logic [AW-1:0] COLS_A = AW'(MAX_COLS);

    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // Read slots of a compute item
    localparam logic [2:0] SLOT_CENTER = 3'd0;
    localparam logic [2:0] SLOT_UP     = 3'd1;
    localparam logic [2:0] SLOT_DOWN   = 3'd2;
    localparam logic [2:0] SLOT_LEFT   = 3'd3;
    localparam logic [2:0] SLOT_RIGHT  = 3'd4;
    localparam logic [2:0] SLOT_LAST   = 3'd5;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_RND  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] rd_cnt_reg, rd_cnt_next;

    logic [COEFF_W-1:0] rate_coeff_reg;
    logic [DIM_W-1:0]   rows_in_use_reg;
    logic [DIM_W-1:0]   cols_in_use_reg;

    // Unpack the input beat
    opcode_t            in_op;
    logic [CW-1:0]      in_row;
    logic [CW-1:0]      in_col;
    logic [VALUE_W-1:0] in_value;

    assign in_op    = opcode_t'(s_tuser);
    assign in_row   = CW'(s_tdata[COORD_W-1:0]);
    assign in_col   = CW'(s_tdata[2*COORD_W-1:COORD_W]);
    assign in_value = s_tdata[2*COORD_W+VALUE_W-1:2*COORD_W];

    logic in_fire;
    logic load_fire;
    logic comp_fire;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign load_fire = in_fire && (in_op == OP_LOAD);
    assign comp_fire = in_fire && (in_op == OP_COMPUTE);

    // Config writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_coeff_reg  <= RATE_COEFF_RST;
            rows_in_use_reg <= ROWS_RST;
            cols_in_use_reg <= COLS_RST;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_RATE_COEFF:  rate_coeff_reg  <= cfg_data[COEFF_W-1:0];
                CFG_ROWS_IN_USE: rows_in_use_reg <= cfg_data[DIM_W-1:0];
                CFG_COLS_IN_USE: cols_in_use_reg <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Grid size in use, clamped to [2, MAX]
    logic [CW-1:0] nr, nc, nr_m1, nc_m1;
    logic [CW-1:0] rows_ext, cols_ext;

    assign rows_ext = CW'(rows_in_use_reg);
    assign cols_ext = CW'(cols_in_use_reg);
    assign nr = (rows_ext < MIN_C) ? MIN_C : ((rows_ext > ROWS_C) ? ROWS_C : rows_ext);
    assign nc = (cols_ext < MIN_C) ? MIN_C : ((cols_ext > COLS_C) ? COLS_C : cols_ext);
    assign nr_m1 = nr - CW'(1);
    assign nc_m1 = nc - CW'(1);

    // Compute coordinates: clamp into the area in use, then wrap neighbors
    logic [CW-1:0] cr, cc, up, dn, lf, rt;

    assign cr = (in_row > nr_m1) ? nr_m1 : in_row;
    assign cc = (in_col > nc_m1) ? nc_m1 : in_col;
    assign up = (cr == '0) ? nr_m1 : cr - CW'(1);
    assign dn = (cr == nr_m1) ? '0 : cr + CW'(1);
    assign lf = (cc == '0) ? nc_m1 : cc - CW'(1);
    assign rt = (cc == nc_m1) ? '0 : cc + CW'(1);

    // Load coordinates: clamp into the parameter grid
    logic [CW-1:0] lr, lc;
    logic [AW-1:0] load_addr;

    assign lr = (in_row > ROWS_C - CW'(1)) ? ROWS_C - CW'(1) : in_row;
    assign lc = (in_col > COLS_C - CW'(1)) ? COLS_C - CW'(1) : in_col;
    assign load_addr = AW'(lr) * COLS_A + AW'(lc);

    logic [CW-1:0] r_reg, c_reg, up_reg, dn_reg, lf_reg, rt_reg;

    always_ff @(posedge aclk) begin
        if (comp_fire) begin
            r_reg  <= cr;
            c_reg  <= cc;
            up_reg <= up;
            dn_reg <= dn;
            lf_reg <= lf;
            rt_reg <= rt;
        end
    end

    // Read address per slot
    logic [CW-1:0] rd_row, rd_col;
    logic [AW-1:0] read_addr;

    always_comb begin
        rd_row = r_reg;
        rd_col = c_reg;
        unique case (rd_cnt_reg)
            SLOT_UP:    rd_row = up_reg;
            SLOT_DOWN:  rd_row = dn_reg;
            SLOT_LEFT:  rd_col = lf_reg;
            SLOT_RIGHT: rd_col = rt_reg;
            default: ;
        endcase
    end

    assign read_addr = AW'(rd_row) * COLS_A + AW'(rd_col);

    // Grid memory
    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      mem_addr;
    logic [VALUE_W-1:0] mem_rdata;

    assign mem_we   = load_fire;
    assign mem_re   = (state_reg == ST_READ) && (rd_cnt_reg != SLOT_LAST);
    assign mem_addr = (state_reg == ST_IDLE) ? load_addr : read_addr;

    pld_grid_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_grid (
        .aclk    (aclk),
        .we      (mem_we),
        .re      (mem_re),
        .addr    (mem_addr),
        .wr_data (in_value),
        .rd_data (mem_rdata)
    );

    // Sequencer
    logic out_free;
    assign out_free = !m_tvalid || m_tready;

    always_comb begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                rd_cnt_next = SLOT_CENTER;
                if (load_fire) begin
                    state_next = ST_DONE;
                end else if (comp_fire) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (rd_cnt_reg == SLOT_LAST) begin
                    state_next = ST_MUL;
                end else begin
                    rd_cnt_next = rd_cnt_reg + 3'd1;
                end
            end
            ST_MUL:  state_next = ST_RND;
            ST_RND:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rd_cnt_reg <= SLOT_CENTER;
        end else begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
        end
    end

    // Datapath: accumulate neighbors minus four times center
    logic signed [DIFF_W-1:0]  rd_ext;
    logic signed [VALUE_W-1:0] old_reg;
    logic signed [DIFF_W-1:0]  acc_reg;
    logic signed [COEFF_W:0]   k_s;
    logic signed [PROD_W-1:0]  prod_reg;

    assign rd_ext = {{(DIFF_W-VALUE_W){mem_rdata[VALUE_W-1]}}, mem_rdata};
    assign k_s    = {1'b0, rate_coeff_reg};

    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            if (rd_cnt_reg == SLOT_UP) begin
                // center word arrives first
                old_reg <= mem_rdata;
                acc_reg <= -(rd_ext <<< 2);
            end else if (rd_cnt_reg != SLOT_CENTER) begin
                acc_reg <= acc_reg + rd_ext;
            end
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= acc_reg * k_s;
        end
    end

    // Round half up, add center, saturate
    logic signed [PROD_W-1:0]  biased;
    logic signed [STEP_W-1:0]  step;
    logic signed [SUM_W-1:0]   sum;
    logic                      sum_fits;

    assign biased   = prod_reg + PROD_W'(ROUND_HALF);
    assign step     = biased[PROD_W-1:FRAC_SHIFT];
    assign sum      = {{(SUM_W-VALUE_W){old_reg[VALUE_W-1]}}, old_reg}
                    + {step[STEP_W-1], step};
    assign sum_fits = (sum[SUM_W-1:VALUE_W-1] == '0) || (sum[SUM_W-1:VALUE_W-1] == '1);

    logic [VALUE_W-1:0] res_value_reg;
    logic               res_sat_reg;

    always_ff @(posedge aclk) begin
        if (load_fire) begin
            res_value_reg <= in_value;
            res_sat_reg   <= 1'b0;
        end else if (state_reg == ST_RND) begin
            if (sum_fits) begin
                res_value_reg <= sum[VALUE_W-1:0];
                res_sat_reg   <= 1'b0;
            end else begin
                res_value_reg <= sum[SUM_W-1] ? VAL_MIN : VAL_MAX;
                res_sat_reg   <= 1'b1;
            end
        end
    end

    // Output register: hold the beat while the receiver stalls
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;
    logic                 out_load;

    assign out_load      = (state_reg == ST_DONE) && out_free;
    assign m_tvalid_next = out_load || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= M_TDATA_W'(res_value_reg);
            m_tuser_reg <= res_sat_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_write_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_IDLE))
        else $error("grid write outside idle");

    a_compute_starts_read: assert property (@(posedge aclk) disable iff (!aresetn)
        comp_fire |=> (state_reg == ST_READ) && (rd_cnt_reg == SLOT_CENTER))
        else $error("compute beat did not start the read sequence");

    a_load_to_done: assert property (@(posedge aclk) disable iff (!aresetn)
        load_fire |=> (state_reg == ST_DONE) && !res_sat_reg)
        else $error("load beat did not go straight to hand-off");

    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (rd_cnt_reg <= SLOT_LAST))
        else $error("read slot counter overran");

    a_sat_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> ((m_tdata == VAL_MAX) || (m_tdata == VAL_MIN)))
        else $error("saturation flag with a value that is not a rail");
`endif

endmodule

// ===== verif/tb_periodic_laplacian_diffusion_step_top.sv =====
`timescale 1ns / 100ps

module tb_periodic_laplacian_diffusion_step_top;
    import pld_pkg::*;

    localparam int ADDR_W = $clog2(DEF_MAX_ROWS * DEF_MAX_COLS);
    localparam int CELLS  = DEF_MAX_ROWS * DEF_MAX_COLS;

    localparam longint Q_MAX = (64'sd1 <<< 31) - 1;
    localparam longint Q_MIN = -(64'sd1 <<< 31);

    localparam logic [VALUE_W-1:0] V_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] V_MAX = 32'h7FFF_FFFF;

    typedef struct {
        opcode_t            op;
        bit [COORD_W-1:0]   row;
        bit [COORD_W-1:0]   col;
        bit [VALUE_W-1:0]   value;
    } cell_cmd_t;

    typedef struct {
        bit [VALUE_W-1:0]   value;
        bit                 clipped;
    } cell_result_t;

    // Center, up, down, left, right as flat grid addresses
    typedef bit [4:0][ADDR_W-1:0] stencil_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // row[5:0], col[11:6], cell_value[43:12]
    logic                  s_tuser   = 1'b0; // opcode[0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // new_value[31:0]
    logic                  m_tuser;          // saturated[0]
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    periodic_laplacian_diffusion_step_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register shadow, written only while the block is idle
    bit [COEFF_W-1:0] rate_k    = RATE_COEFF_RST;
    bit [DIM_W-1:0]   rows_cfg  = ROWS_RST;
    bit [DIM_W-1:0]   cols_cfg  = COLS_RST;

    // Grid as the block should hold it, updated on each accepted load beat
    bit [VALUE_W-1:0] grid_now [0:CELLS-1];
    // Cells for which the stimulus has already queued a load
    bit               cell_loaded [0:CELLS-1];

    cell_cmd_t        items_todo[$];
    cell_result_t     results_due[$];
    cell_cmd_t        s_item;

    int               items_queued = 0;
    int               items_sent   = 0;
    int               pause_mark   = -1;
    int               errors       = 0;

    // Handshake flags: set at the rising edge, consumed at the falling edge
    bit               s_taken = 1'b0;
    bit               m_taken = 1'b0;
    int               s_wait  = 0;
    int               m_hold  = 0;
    bit               s_burst = 1'b0;
    bit               m_burst = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(3_000_000);
        $display("[periodic_laplacian_diffusion_step_top] ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stencil and prediction
    // ---------------------------------------------------------------

    function automatic int unsigned dim_eff(bit [DIM_W-1:0] d, int unsigned top);
        if (d < MIN_DIM) return MIN_DIM;
        if (d > top)     return top;
        return 32'(d);
    endfunction

    // Clamp the address into the area in use and wrap the four neighbors
    function automatic stencil_t stencil_of(bit [COORD_W-1:0] row, bit [COORD_W-1:0] col);
        int unsigned nr, nc, r, c;
        stencil_t    s;
        nr = dim_eff(rows_cfg, DEF_MAX_ROWS);
        nc = dim_eff(cols_cfg, DEF_MAX_COLS);
        r  = (32'(row) >= nr) ? nr - 1 : 32'(row);
        c  = (32'(col) >= nc) ? nc - 1 : 32'(col);
        s[0] = ADDR_W'(r * DEF_MAX_COLS + c);
        s[1] = ADDR_W'(((r == 0) ? nr - 1 : r - 1) * DEF_MAX_COLS + c);
        s[2] = ADDR_W'(((r + 1 == nr) ? 0 : r + 1) * DEF_MAX_COLS + c);
        s[3] = ADDR_W'(r * DEF_MAX_COLS + ((c == 0) ? nc - 1 : c - 1));
        s[4] = ADDR_W'(r * DEF_MAX_COLS + ((c + 1 == nc) ? 0 : c + 1));
        return s;
    endfunction

    function automatic longint cell_word(bit [ADDR_W-1:0] a);
        int w;
        w = grid_now[a];
        return longint'(w);
    endfunction

    // Result of one accepted beat; a load also updates the grid
    function automatic cell_result_t diffused_cell(cell_cmd_t cmd);
        cell_result_t res;
        stencil_t     s;
        longint       centre, diff, prod, step, total, kv;
        res.clipped = 1'b0;
        if (cmd.op == OP_LOAD) begin
            grid_now[ADDR_W'(cmd.row * DEF_MAX_COLS + cmd.col)] = cmd.value;
            res.value = cmd.value;
            return res;
        end
        s      = stencil_of(cmd.row, cmd.col);
        centre = cell_word(s[0]);
        diff   = cell_word(s[1]) + cell_word(s[2]) + cell_word(s[3]) + cell_word(s[4])
                 - 4 * centre;
        kv     = longint'(rate_k);
        prod   = diff * kv;
        // Floor after adding one half: round half toward plus infinity
        step   = (prod + ROUND_HALF) >>> FRAC_SHIFT;
        total  = centre + step;
        if (total > Q_MAX) begin
            total       = Q_MAX;
            res.clipped = 1'b1;
        end else if (total < Q_MIN) begin
            total       = Q_MIN;
            res.clipped = 1'b1;
        end
        res.value = total[VALUE_W-1:0];
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus construction
    // ---------------------------------------------------------------

    function automatic bit [VALUE_W-1:0] rand_value();
        int v;
        case ($urandom_range(0, 7))
            0:       return V_MIN;
            1:       return V_MAX;
            2:       return ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
            3, 4:    return $urandom;
            default: begin
                v = int'($urandom_range(0, 2097152)) - 1048576;
                return v;
            end
        endcase
    endfunction

    // Mostly inside the area in use, sometimes past it to hit the clamp
    function automatic bit [COORD_W-1:0] pick_coord(int unsigned n);
        if ($urandom_range(0, 4) == 0) return COORD_W'($urandom_range(0, DEF_MAX_ROWS - 1));
        return COORD_W'($urandom_range(0, n - 1));
    endfunction

    function automatic void push_load(bit [COORD_W-1:0] row, bit [COORD_W-1:0] col,
                                      bit [VALUE_W-1:0] value);
        cell_cmd_t cmd;
        cmd.op    = OP_LOAD;
        cmd.row   = row;
        cmd.col   = col;
        cmd.value = value;
        cell_loaded[ADDR_W'(row * DEF_MAX_COLS + col)] = 1'b1;
        items_todo = {items_todo, cmd};
        items_queued++;
    endfunction

    // Load any stencil cell not yet written, then queue the compute itself
    function automatic void push_compute(bit [COORD_W-1:0] row, bit [COORD_W-1:0] col);
        cell_cmd_t cmd;
        stencil_t  s;
        s = stencil_of(row, col);
        for (int i = 0; i < 5; i++) begin
            if (!cell_loaded[s[i]])
                push_load(COORD_W'(s[i] / DEF_MAX_COLS), COORD_W'(s[i] % DEF_MAX_COLS),
                          rand_value());
        end
        cmd.op    = OP_COMPUTE;
        cmd.row   = row;
        cmd.col   = col;
        cmd.value = $urandom;
        items_todo = {items_todo, cmd};
        items_queued++;
    endfunction

    function automatic void add_random(int n);
        int          target;
        int unsigned nr, nc;
        target = items_queued + n;
        nr     = dim_eff(rows_cfg, DEF_MAX_ROWS);
        nc     = dim_eff(cols_cfg, DEF_MAX_COLS);
        while (items_queued < target) begin
            if ($urandom_range(0, 9) < 3)
                push_load(COORD_W'($urandom_range(0, DEF_MAX_ROWS - 1)),
                          COORD_W'($urandom_range(0, DEF_MAX_COLS - 1)), rand_value());
            else
                push_compute(pick_coord(nr), pick_coord(nc));
        end
    endfunction

    function automatic int draw_wait(bit busy);
        if (!busy) return 0;
        return $urandom_range(0, 14);
    endfunction

    // ---------------------------------------------------------------
    // Configuration and phase control
    // ---------------------------------------------------------------

    task automatic write_reg(cfg_reg_t idx, bit [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_RATE_COEFF:  rate_k   = val[COEFF_W-1:0];
            CFG_ROWS_IN_USE: rows_cfg = val[DIM_W-1:0];
            CFG_COLS_IN_USE: cols_cfg = val[DIM_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Block until every queued beat went in and every result came back
    task automatic wait_idle();
        do @(posedge aclk);
        while (items_todo.size() != 0 || s_tvalid || results_due.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_grid(bit [COEFF_W-1:0] k, bit [DIM_W-1:0] rows, bit [DIM_W-1:0] cols);
        wait_idle();
        write_reg(CFG_RATE_COEFF, k);
        write_reg(CFG_ROWS_IN_USE, rows);
        write_reg(CFG_COLS_IN_USE, cols);
    endtask

    task automatic run_phase(bit [COEFF_W-1:0] k, bit [DIM_W-1:0] rows,
                             bit [DIM_W-1:0] cols, int n);
        set_grid(k, rows, cols);
        // Hold the sender once mid-phase until the output side drains
        pause_mark = items_queued + n / 2;
        add_random(n);
    endtask

    // ---------------------------------------------------------------
    // Input driver: one beat per queued item, random gap after each
    // ---------------------------------------------------------------

    always @(negedge aclk) begin
        if (aresetn && (s_taken || !s_tvalid)) begin
            s_taken = 1'b0;
            if (s_wait > 0) begin
                s_wait--;
                s_tvalid <= 1'b0;
            end else if (items_todo.size() != 0 &&
                         !(items_sent == pause_mark && results_due.size() != 0)) begin
                s_item = items_todo.pop_front();
                items_sent++;
                s_tdata  <= {{(S_TDATA_W - VALUE_W - 2 * COORD_W){1'b0}},
                             s_item.value, s_item.col, s_item.row};
                s_tuser  <= s_item.op;
                s_tvalid <= 1'b1;
                s_wait    = draw_wait(s_burst);
                if ($urandom_range(0, 39) == 0) s_burst = !s_burst;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Output ready: random stall before each result beat
    // ---------------------------------------------------------------

    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_taken) begin
                m_taken = 1'b0;
                m_hold  = draw_wait(m_burst);
                if ($urandom_range(0, 39) == 0) m_burst = !m_burst;
            end
            if (m_hold > 0) begin
                m_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: check result beats, predict on accepted input beats
    // ---------------------------------------------------------------

    always @(posedge aclk) begin : monitor
        cell_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                m_taken = 1'b1;
                if (results_due.size() == 0) begin
                    $display("%0t: result beat with nothing pending: value %h sat %b",
                             $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    if (m_tdata !== want.value) begin
                        $display("%0t: new_value expected %h actual %h",
                                 $time, want.value, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== want.clipped) begin
                        $display("%0t: saturated expected %b actual %b",
                                 $time, want.clipped, m_tuser);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                s_taken = 1'b1;
                results_due = {results_due, diffused_cell(s_item)};
            end
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------

    initial begin
        foreach (cell_loaded[i]) begin
            cell_loaded[i] = 1'b0;
            grid_now[i]    = '0;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: k = 0 so a compute returns its center; corners wrap
        push_load(6'd0, 6'd0, V_MIN);
        push_load(6'd63, 6'd63, V_MAX);
        push_compute(6'd0, 6'd0);
        push_compute(6'd63, 6'd63);
        push_load(6'd42, 6'd21, 32'h5555_5555);
        push_load(6'd21, 6'd42, 32'hAAAA_AAAA);

        // Smallest torus with full k: drive both clip directions
        set_grid(16'hFFFF, 7'd2, 7'd2);
        push_load(6'd0, 6'd0, V_MIN);
        push_load(6'd0, 6'd1, V_MAX);
        push_load(6'd1, 6'd0, V_MAX);
        push_load(6'd1, 6'd1, V_MIN);
        push_compute(6'd0, 6'd0);
        push_compute(6'd0, 6'd1);
        push_compute(6'd63, 6'd63);   // past the area in use, lands on (1,1)
        push_compute(6'd1, 6'd0);

        run_phase(16'h8000, 7'd64, 7'd64, 160);
        run_phase(COEFF_W'($urandom), 7'd2, 7'd64, 160);
        run_phase(COEFF_W'($urandom), 7'd64, 7'd2, 160);
        run_phase(16'hFFFF, 7'd0, 7'd127, 160);
        run_phase(16'h0000, 7'd1, 7'd65, 160);
        run_phase(COEFF_W'($urandom), 7'd3, 7'd5, 160);
        run_phase(COEFF_W'($urandom), DIM_W'($urandom_range(2, 64)),
                  DIM_W'($urandom_range(2, 64)), 160);
        run_phase(16'h0001, 7'd100, 7'd33, 160);

        wait_idle();
        repeat (20) @(posedge aclk);
        if (errors == 0 && results_due.size() == 0) begin
            $display("[periodic_laplacian_diffusion_step_top] OK");
        end else begin
            $display("[periodic_laplacian_diffusion_step_top] ERROR");
        end
        $finish;
    end

endmodule
